// ===== hw/rtl/nhap_pkg.sv =====
package nhap_pkg;

  localparam int MaxAreas = 32;
  localparam int IdxW     = $clog2(MaxAreas);
  localparam int CountW   = $clog2(MaxAreas + 1);
  localparam int ThrW     = 12;
  localparam int SqW      = 34;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  localparam logic [2:0] CandCentre   = 3'd0;
  localparam logic [2:0] CandTopLeft  = 3'd1;
  localparam logic [2:0] CandTopRight = 3'd2;
  localparam logic [2:0] CandBotLeft  = 3'd3;
  localparam logic [2:0] CandBotRight = 3'd4;

  typedef enum logic [1:0] {
    ScanContain,
    ScanNear,
    ScanIsolate
  } scan_mode_e;

  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic signed [15:0] display_x;
    logic signed [15:0] display_y;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic               clash;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } rect_t;

  typedef struct packed {
    logic       take;
    logic       scan_start;
    scan_mode_e mode;
    logic       best_init;
    logic       load_sel;
    logic       latch_sel;
    logic       cand_next;
    logic       cur_take;
    logic       set_clash;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic have;
    logic iso_hit;
    logic cand_last;
  } sts_t;

  // centre of an inclusive span, halved toward zero
  function automatic logic signed [15:0] centre16(logic signed [15:0] a,
                                                  logic signed [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {a[15], a} + {b[15], b};
    t = s + {16'd0, s[16]};
    return t[16:1];
  endfunction

  function automatic logic rect_hit(rect_t r, logic signed [16:0] x,
                                    logic signed [16:0] y);
    logic signed [16:0] l;
    logic signed [16:0] t;
    logic signed [16:0] rr;
    logic signed [16:0] b;
    l  = {r.left[15], r.left};
    t  = {r.top[15], r.top};
    rr = {r.right[15], r.right};
    b  = {r.bottom[15], r.bottom};
    return (x >= l) && (y >= t) && (x <= rr) && (y <= b);
  endfunction

endpackage

// ===== hw/rtl/nhap_ctrl.sv =====
module nhap_ctrl import nhap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  logic       out_free_i,
  input  sts_t       sts_i,
  output logic       in_stall_o,
  output logic       emit_o,
  output cmd_t       cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCont  = 3'd1;
  localparam logic [2:0] StNear  = 3'd2;
  localparam logic [2:0] StLoad  = 3'd3;
  localparam logic [2:0] StLatch = 3'd4;
  localparam logic [2:0] StIso   = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mode = ScanContain;
    emit_o     = 1'b0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_op_i == OpQuery) begin
            cmd_o.scan_start = 1'b1;
            state_d          = StCont;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StCont: begin
        cmd_o.mode = ScanContain;
        if (!sts_i.scan_busy) begin
          if (sts_i.have) begin
            state_d = StLoad;
          end else begin
            cmd_o.scan_start = 1'b1;
            cmd_o.best_init  = 1'b1;
            state_d          = StNear;
          end
        end
      end
      StNear: begin
        cmd_o.mode = ScanNear;
        if (!sts_i.scan_busy) begin
          state_d = sts_i.have ? StLoad : StEmit;
        end
      end
      StLoad: begin
        cmd_o.load_sel = 1'b1;
        state_d        = StLatch;
      end
      StLatch: begin
        cmd_o.latch_sel  = 1'b1;
        cmd_o.scan_start = 1'b1;
        cmd_o.mode       = ScanIsolate;
        state_d          = StIso;
      end
      StIso: begin
        cmd_o.mode = ScanIsolate;
        if (!sts_i.scan_busy) begin
          if (!sts_i.iso_hit) begin
            cmd_o.cur_take = 1'b1;
            state_d        = StEmit;
          end else if (sts_i.cand_last) begin
            cmd_o.set_clash = 1'b1;
            state_d         = StEmit;
          end else begin
            cmd_o.cand_next  = 1'b1;
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      StEmit: begin
        emit_o = 1'b1;
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== hw/rtl/nhap_dp.sv =====
module nhap_dp import nhap_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [ThrW-1:0] cfg_data_i,
  input  in_item_t        in_data_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output out_item_t       res_o
);

  rect_t mem_q [MaxAreas];

  logic [ThrW-1:0]   thr_q;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   idx_q;
  logic              issue_q;
  logic              rv_q, cv_q, dv_q;
  logic              have_q, hit_q, status_q, clash_q;
  logic [2:0]        k_q;
  logic [SqW-1:0]    best_q;
  logic [IdxW-1:0]   sel_q;

  rect_t              rd_q;
  logic [IdxW-1:0]    ridx_q, cidx_q, didx_q;
  logic signed [15:0] px_q, py_q;
  logic signed [16:0] dx_q, dy_q;
  logic [SqW-1:0]     sqx_q, sqy_q;
  rect_t              sel_rect_q;
  logic signed [15:0] cur_x_q, cur_y_q;

  logic               last_idx;
  logic [IdxW-1:0]    rd_addr;
  logic               table_full;
  logic [23:0]        thr_sq;
  logic [SqW-1:0]     dist_sq;
  logic signed [15:0] rcx, rcy, scx, scy;
  logic signed [16:0] rdx, rdy, pxe, pye;
  logic signed [33:0] rsqx, rsqy;
  logic signed [16:0] cand_x, cand_y;

  assign last_idx   = (CountW'(idx_q) + CountW'(1)) == count_q;
  assign rd_addr    = cmd_i.load_sel ? sel_q : idx_q;
  assign table_full = count_q >= CountW'(MaxAreas);
  assign thr_sq     = {12'd0, thr_q} * {12'd0, thr_q};
  assign dist_sq    = sqx_q + sqy_q;
  assign pxe        = {px_q[15], px_q};
  assign pye        = {py_q[15], py_q};
  assign rcx        = centre16(rd_q.left, rd_q.right);
  assign rcy        = centre16(rd_q.top, rd_q.bottom);
  assign rdx        = pxe - {rcx[15], rcx};
  assign rdy        = pye - {rcy[15], rcy};
  assign rsqx       = 34'(dx_q) * 34'(dx_q);
  assign rsqy       = 34'(dy_q) * 34'(dy_q);
  assign scx        = centre16(sel_rect_q.left, sel_rect_q.right);
  assign scy        = centre16(sel_rect_q.top, sel_rect_q.bottom);

  // isolation candidates: centre, then the four corners moved one pixel inward
  always_comb begin
    case (k_q)
      CandCentre: begin
        cand_x = {scx[15], scx};
        cand_y = {scy[15], scy};
      end
      CandTopLeft: begin
        cand_x = {sel_rect_q.left[15], sel_rect_q.left} + 17'sd1;
        cand_y = {sel_rect_q.top[15], sel_rect_q.top} + 17'sd1;
      end
      CandTopRight: begin
        cand_x = {sel_rect_q.right[15], sel_rect_q.right} - 17'sd1;
        cand_y = {sel_rect_q.top[15], sel_rect_q.top} + 17'sd1;
      end
      CandBotLeft: begin
        cand_x = {sel_rect_q.left[15], sel_rect_q.left} + 17'sd1;
        cand_y = {sel_rect_q.bottom[15], sel_rect_q.bottom} - 17'sd1;
      end
      CandBotRight: begin
        cand_x = {sel_rect_q.right[15], sel_rect_q.right} - 17'sd1;
        cand_y = {sel_rect_q.bottom[15], sel_rect_q.bottom} - 17'sd1;
      end
      default: begin
        cand_x = {scx[15], scx};
        cand_y = {scy[15], scy};
      end
    endcase
  end

  // area table
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.operation == OpAppend && !table_full) begin
      mem_q[count_q[IdxW-1:0]] <= '{left:   in_data_i.rect_left,
                                    top:    in_data_i.rect_top,
                                    right:  in_data_i.rect_right,
                                    bottom: in_data_i.rect_bottom};
    end
    if (issue_q || cmd_i.load_sel) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrW'(40);
      count_q  <= '0;
      idx_q    <= '0;
      issue_q  <= 1'b0;
      rv_q     <= 1'b0;
      cv_q     <= 1'b0;
      dv_q     <= 1'b0;
      have_q   <= 1'b0;
      hit_q    <= 1'b0;
      status_q <= 1'b0;
      clash_q  <= 1'b0;
      k_q      <= CandCentre;
      sel_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        have_q   <= 1'b0;
        clash_q  <= 1'b0;
        status_q <= 1'b0;
        case (in_data_i.operation)
          OpClear: begin
            count_q <= '0;
          end
          OpAppend: begin
            if (table_full) begin
              status_q <= 1'b1;
            end else begin
              count_q <= count_q + CountW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      // table scan issue
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        issue_q <= (count_q != '0);
      end else if (issue_q) begin
        idx_q <= idx_q + IdxW'(1);
        if (last_idx) begin
          issue_q <= 1'b0;
        end
      end
      rv_q <= issue_q;
      cv_q <= rv_q && (cmd_i.mode == ScanNear);
      dv_q <= cv_q;
      // containment: last hit wins
      if (rv_q && cmd_i.mode == ScanContain && rect_hit(rd_q, pxe, pye)) begin
        have_q <= 1'b1;
        sel_q  <= ridx_q;
      end
      // nearest centre: later entry wins on a tie
      if (dv_q && dist_sq <= best_q) begin
        have_q <= 1'b1;
        sel_q  <= didx_q;
      end
      if (cmd_i.latch_sel) begin
        k_q   <= CandCentre;
        hit_q <= 1'b0;
      end else if (cmd_i.cand_next) begin
        k_q   <= k_q + 3'd1;
        hit_q <= 1'b0;
      end else if (rv_q && cmd_i.mode == ScanIsolate && ridx_q != sel_q &&
                   rect_hit(rd_q, cand_x, cand_y)) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.set_clash) begin
        clash_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= idx_q;
    cidx_q <= ridx_q;
    didx_q <= cidx_q;
    dx_q   <= rdx;
    dy_q   <= rdy;
    sqx_q  <= SqW'(unsigned'(rsqx));
    sqy_q  <= SqW'(unsigned'(rsqy));
    if (cmd_i.take) begin
      px_q <= in_data_i.point_x;
      py_q <= in_data_i.point_y;
    end
    if (cmd_i.best_init) begin
      best_q <= SqW'(thr_sq);
    end else if (dv_q && dist_sq <= best_q) begin
      best_q <= dist_sq;
    end
    if (cmd_i.latch_sel) begin
      sel_rect_q <= rd_q;
    end
    if (cmd_i.cur_take) begin
      cur_x_q <= cand_x[15:0];
      cur_y_q <= cand_y[15:0];
    end else if (cmd_i.set_clash) begin
      cur_x_q <= scx;
      cur_y_q <= scy;
    end
  end

  assign sts_o.scan_busy = issue_q || rv_q || cv_q || dv_q;
  assign sts_o.have      = have_q;
  assign sts_o.iso_hit   = hit_q;
  assign sts_o.cand_last = (k_q == CandBotRight);

  assign res_o.status    = status_q;
  assign res_o.found     = have_q;
  assign res_o.display_x = have_q ? scx : '0;
  assign res_o.display_y = have_q ? scy : '0;
  assign res_o.cursor_x  = have_q ? cur_x_q : '0;
  assign res_o.cursor_y  = have_q ? cur_y_q : '0;
  assign res_o.clash     = clash_q;

endmodule

// ===== hw/rtl/nearest_hit_area_picker.sv =====
// Rectangle table of MaxAreas entries with a point query. Clear, append and
// unused operations go straight to the result hand-over. A query walks the
// one-read-port table with one entry per cycle: a containment pass, a
// nearest-centre pass when nothing contains the point, a fetch of the chosen
// entry, then one isolation pass for each of up to five candidate points, and
// the hand-over of the result. The result sits in an output register, so the
// next item is taken while it waits for transfer.
module nearest_hit_area_picker import nhap_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ThrW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  cmd_t      cmd;
  sts_t      sts;
  out_item_t res;
  logic      emit;
  logic      out_free;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  nhap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .emit_o     (emit),
    .cmd_o      (cmd)
  );

  nhap_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/sv/tb_nearest_hit_area_picker.sv =====
module tb_nearest_hit_area_picker;
  import nhap_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int HoldCycles = 400;
  localparam int DrainLimit = 100000;
  localparam int SettleCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ThrW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  nearest_hit_area_picker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t items_to_send[$];
  out_item_t picks_due[$];
  rect_t shadow_areas[$];
  out_item_t want_pick;

  // model of the area table and threshold
  rect_t area_tab[MaxAreas];
  int area_cnt = 0;
  int dist_limit = 40;

  int send_idle_pct = 6;
  int recv_idle_pct = 50;
  logic hold_req = 1'b0;
  logic hold_done;
  int hold_left;

  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_clash = 0;
  int n_refused = 0;
  int n_errors = 0;

  function automatic bit covers(rect_t a, int x, int y);
    return x >= a.left && y >= a.top && x <= a.right && y <= a.bottom;
  endfunction

  function automatic bit lonely(int x, int y, int self);
    for (int i = 0; i < area_cnt; i++) begin
      if (i != self && covers(area_tab[i], x, y)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t pick_area(in_item_t it);
    out_item_t res;
    int px, py, sel, cx, cy, l, t, r, b;
    int cand_x[5];
    int cand_y[5];
    bit have, done;
    longint best, dx, dy, d;
    res = '0;
    case (it.operation)
      OpClear: area_cnt = 0;
      OpAppend: begin
        if (area_cnt >= MaxAreas) begin
          res.status = 1'b1;
          n_refused++;
        end else begin
          area_tab[area_cnt] = '{it.rect_left, it.rect_top, it.rect_right, it.rect_bottom};
          area_cnt++;
        end
      end
      OpQuery: begin
        px = int'(it.point_x);
        py = int'(it.point_y);
        have = 1'b0;
        sel = 0;
        for (int i = 0; i < area_cnt; i++) begin
          if (covers(area_tab[i], px, py)) begin
            have = 1'b1;
            sel = i;
          end
        end
        if (!have) begin
          best = longint'(dist_limit) * dist_limit;
          for (int i = 0; i < area_cnt; i++) begin
            cx = (int'(area_tab[i].left) + int'(area_tab[i].right)) / 2;
            cy = (int'(area_tab[i].top) + int'(area_tab[i].bottom)) / 2;
            dx = longint'(px - cx);
            dy = longint'(py - cy);
            d = dx * dx + dy * dy;
            if (d <= best) begin
              best = d;
              have = 1'b1;
              sel = i;
            end
          end
        end
        if (have) begin
          l = int'(area_tab[sel].left);
          t = int'(area_tab[sel].top);
          r = int'(area_tab[sel].right);
          b = int'(area_tab[sel].bottom);
          cx = (l + r) / 2;
          cy = (t + b) / 2;
          cand_x = '{cx, l + 1, r - 1, l + 1, r - 1};
          cand_y = '{cy, t + 1, t + 1, b - 1, b - 1};
          res.found = 1'b1;
          res.display_x = cx[15:0];
          res.display_y = cy[15:0];
          res.cursor_x = cx[15:0];
          res.cursor_y = cy[15:0];
          done = 1'b0;
          for (int k = 0; k < 5 && !done; k++) begin
            if (lonely(cand_x[k], cand_y[k], sel)) begin
              res.cursor_x = cand_x[k][15:0];
              res.cursor_y = cand_y[k][15:0];
              done = 1'b1;
            end
          end
          res.clash = !done;
          n_hits++;
          if (!done) n_clash++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        picks_due.push_back(pick_area(in_data_i));
        n_sent++;
      end
      if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= items_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none got %h", $time, out_data_o);
        n_errors++;
      end else begin
        want_pick = picks_due.pop_front();
        cmp_field("status", 16'(want_pick.status), 16'(out_data_o.status));
        cmp_field("found", 16'(want_pick.found), 16'(out_data_o.found));
        cmp_field("display_x", want_pick.display_x, out_data_o.display_x);
        cmp_field("display_y", want_pick.display_y, out_data_o.display_y);
        cmp_field("cursor_x", want_pick.cursor_x, out_data_o.cursor_x);
        cmp_field("cursor_y", want_pick.cursor_y, out_data_o.cursor_y);
        cmp_field("clash", 16'(want_pick.clash), 16'(out_data_o.clash));
        n_checked++;
      end
    end
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int jitter(int s);
    return int'($urandom_range(2 * s)) - s;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    logic [127:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  task automatic push_op(logic [1:0] op);
    items_to_send.push_back(rand_item(op));
  endtask

  task automatic push_append(logic signed [15:0] l, logic signed [15:0] t,
                             logic signed [15:0] r, logic signed [15:0] b);
    in_item_t it;
    it = rand_item(OpAppend);
    it.rect_left = l;
    it.rect_top = t;
    it.rect_right = r;
    it.rect_bottom = b;
    items_to_send.push_back(it);
  endtask

  task automatic push_query(logic signed [15:0] x, logic signed [15:0] y);
    in_item_t it;
    it = rand_item(OpQuery);
    it.point_x = x;
    it.point_y = y;
    items_to_send.push_back(it);
  endtask

  function automatic rect_t make_rect(int ox, int oy, int spread);
    rect_t a;
    int cx, cy, pick;
    pick = $urandom_range(99);
    cx = ox + jitter(spread);
    cy = oy + jitter(spread);
    if (pick < 6) begin
      a = {$urandom(), $urandom()};
    end else if (pick < 12) begin
      a.left = clamp16(cx + 5);
      a.right = clamp16(cx - 5);
      a.top = clamp16(cy - 3);
      a.bottom = clamp16(cy + 3);
    end else begin
      a.left = clamp16(cx - int'($urandom_range(40)));
      a.right = clamp16(cx + int'($urandom_range(40)));
      a.top = clamp16(cy - int'($urandom_range(40)));
      a.bottom = clamp16(cy + int'($urandom_range(40)));
    end
    return a;
  endfunction

  task automatic push_aimed_query();
    rect_t a;
    int l, t, r, b, reach, mode;
    a = shadow_areas[$urandom_range(shadow_areas.size() - 1)];
    l = int'(a.left);
    t = int'(a.top);
    r = int'(a.right);
    b = int'(a.bottom);
    reach = (dist_limit < 200 ? dist_limit : 200) + 2;
    mode = $urandom_range(99);
    if (mode < 40 && l <= r && t <= b)
      push_query(clamp16(l + int'($urandom_range(r - l))),
                 clamp16(t + int'($urandom_range(b - t))));
    else if (mode < 70)
      push_query(clamp16((l + r) / 2 + jitter(reach)), clamp16((t + b) / 2 + jitter(reach)));
    else if (mode < 85)
      push_query(clamp16($urandom_range(1) ? l + 1 : r - 1),
                 clamp16($urandom_range(1) ? t + 1 : b - 1));
    else
      push_query(16'($urandom()), 16'($urandom()));
  endtask

  // mostly clear, fill, query runs; some stray items of any operation
  task automatic gen_phase(int n_items);
    int made, fill, spread, ox, oy;
    rect_t a;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 12) begin
        push_op(2'($urandom_range(3)));
        made++;
      end else begin
        shadow_areas.delete();
        push_op(OpClear);
        fill = ($urandom_range(99) < 8) ? $urandom_range(30, 34) : $urandom_range(1, 8);
        spread = $urandom_range(1) ? 24 : 3000;
        ox = int'($urandom_range(65535)) - 32768;
        oy = int'($urandom_range(65535)) - 32768;
        repeat (fill) begin
          a = make_rect(ox, oy, spread);
          shadow_areas.push_back(a);
          push_append(a.left, a.top, a.right, a.bottom);
        end
        made += fill + 1;
        repeat ($urandom_range(2, 6)) begin
          push_aimed_query();
          made++;
        end
      end
    end
  endtask

  task automatic drain();
    for (int i = 0; i < DrainLimit &&
         (items_to_send.size() != 0 || in_valid_i || picks_due.size() != 0); i++)
      @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dist_limit = int'(v);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, unused code, overlapping areas, edge-of-range corners
    push_query(16'sd0, 16'sd0);
    push_op(OpUnused);
    push_append(-32768, -32768, 32767, 32767);
    push_append(10, 10, 20, 20);
    push_query(15, 15);
    push_op(OpClear);
    push_append(-32768, -32768, -32767, -32767);
    push_append(-32768, -32768, -32768, -32768);
    push_query(-32768, -32768);
    push_append(32766, 32766, 32767, 32767);
    push_append(32767, 32767, 32767, 32767);
    push_query(32767, 32767);
    // inverted area, equal distances, threshold boundary
    push_op(OpClear);
    push_append(100, 100, 50, 50);
    push_query(80, 80);
    push_append(200, 0, 200, 0);
    push_append(210, 0, 210, 0);
    push_query(205, 0);
    push_query(250, 0);
    push_query(300, 300);

    write_threshold(12'd4095);
    gen_phase(200);

    write_threshold(12'd0);
    send_idle_pct = 50;
    recv_idle_pct = 6;
    gen_phase(200);

    write_threshold(12'($urandom_range(1, 4094)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    gen_phase(100);

    write_threshold(12'($urandom_range(4095)));
    gen_phase(100);

    drain();
    if (picks_due.size() != 0) begin
      $display("%0t: %0d results expected but never transferred", $time, picks_due.size());
      n_errors++;
    end
    repeat (SettleCycles) @(negedge clk_i);

    $display("%0d items sent, %0d results checked over five threshold settings",
             n_sent, n_checked);
    $display("%0d queries picked an area, %0d fell back to the centre, %0d appends refused",
             n_hits, n_clash, n_refused);
    if (n_errors == 0)
      $display("tb_nearest_hit_area_picker OK");
    else
      $display("tb_nearest_hit_area_picker NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish", $time);
    $display("tb_nearest_hit_area_picker NOT OK");
    $finish;
  end

endmodule
